/* hw/rtl/vfrt_pkg.sv */
// shared types and constants of the video fragment reassembly tracker
`timescale 1ns / 1ps
`default_nettype none
package vfrt_pkg;

  localparam int SLOTS           = 4;
  localparam int CHUNK_BYTES     = 1000;
  localparam int MAX_FRAME_BYTES = 4 * 1024 * 1024;
  localparam int MAX_CHUNKS      = 4195;
  localparam int HDR_BYTES       = 8;

  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);
  localparam int SIZE_W     = $clog2(MAX_FRAME_BYTES + 1);
  localparam int SEEN_DEPTH = SLOTS * MAX_CHUNKS;
  localparam int SEEN_AW    = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
  localparam int EPOCH_W    = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
  localparam int FIFO_DEPTH = 2;

  localparam logic [15:0] TIMEOUT_RST = 16'd250;
  localparam logic [15:0] MIN_DIM_RST = 16'd64;
  localparam logic [15:0] MAX_W_RST   = 16'd3840;
  localparam logic [15:0] MAX_H_RST   = 16'd2160;

  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_MIN_DIM = 2'd1,
    REG_MAX_W   = 2'd2,
    REG_MAX_H   = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_STALE     = 3'd2,
    ST_MALFORMED = 3'd3,
    ST_DUPLICATE = 3'd4,
    ST_BAD_DIM   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_INIT,
    B_IDLE,
    B_CHECK,
    B_LOOKUP,
    B_EVICT,
    B_ALLOC,
    B_SWEEP,
    B_READ,
    B_TEST,
    B_DONE,
    B_OUT
  } back_state_e;

  typedef struct packed {
    logic [63:0] frame_number;
    logic        is_keyframe;
    logic [10:0] fragment_length;
    logic [15:0] chunk_index;
    logic [15:0] chunk_total;
    logic [31:0] frame_bytes;
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [1:0]  slot;
    logic [21:0] write_offset;
    logic        frame_keyframe;
    logic [31:0] frame_width;
    logic [31:0] frame_height;
  } out_item_t;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [15:0] min_dimension;
    logic [15:0] max_width;
    logic [15:0] max_height;
  } cfg_t;

  // classified descriptor handed from front to back
  typedef struct packed {
    logic [63:0]       frame_number;
    logic              is_keyframe;
    logic              short_len;
    logic              malformed;
    logic [CNT_W-1:0]  chunk_index;
    logic [CNT_W-1:0]  chunk_total;
    logic [SIZE_W-1:0] frame_bytes;
    logic [SIZE_W-1:0] offset;
    logic [31:0]       first_word;
    logic [31:0]       second_word;
    logic [31:0]       now_ms;
  } job_t;

endpackage
`default_nettype wire

/* hw/rtl/video_fragment_reassembly_tracker.sv */
// top level of the video fragment reassembly tracker
`timescale 1ns / 1ps
`default_nettype none
// Tracks reassembly of up to SLOTS video frames from parsed fragment descriptors,
// one result per descriptor. The front end registers a descriptor, forms the
// chunk-size products, runs the length, count and index checks and then pushes
// it into a two-entry queue. The back end is a sequencer: check and aging, slot
// lookup, a lowest-id eviction scan when the table is full, optional allocation,
// a read and a test of the seen-chunk memory, an optional completion step, and
// the output load. The back end sequencer and its single seen-memory write port
// set the rate. Seen marks are epoch tags per slot: allocation bumps the slot
// epoch, and every 255th allocation of a slot sweeps its MAX_CHUNKS rows, one per
// cycle. After reset the whole seen memory (SLOTS*MAX_CHUNKS = 16780 rows) is
// cleared while no descriptor is taken; register writes are taken throughout.
// Results sit in an output register, so the next descriptor is taken while a
// result waits for its transfer.
module video_fragment_reassembly_tracker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vfrt_pkg::in_item_t  in_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output vfrt_pkg::out_item_t out_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import vfrt_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_idx;
  logic     cfg_wr;

  job_t front_job, queue_job;
  logic push, pop, q_empty, q_full, init_busy;

  // register file, byte address 4*index, 16 bits used
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_d  = cfg_q;
    prdata = '0;
    case (reg_idx)
      REG_TIMEOUT: begin
        prdata = 32'(cfg_q.timeout_ms);
        if (cfg_wr) cfg_d.timeout_ms = pwdata[15:0];
      end
      REG_MIN_DIM: begin
        prdata = 32'(cfg_q.min_dimension);
        if (cfg_wr) cfg_d.min_dimension = pwdata[15:0];
      end
      REG_MAX_W: begin
        prdata = 32'(cfg_q.max_width);
        if (cfg_wr) cfg_d.max_width = pwdata[15:0];
      end
      REG_MAX_H: begin
        prdata = 32'(cfg_q.max_height);
        if (cfg_wr) cfg_d.max_height = pwdata[15:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ms    <= TIMEOUT_RST;
      cfg_q.min_dimension <= MIN_DIM_RST;
      cfg_q.max_width     <= MAX_W_RST;
      cfg_q.max_height    <= MAX_H_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front end: stateless checks and chunk offset
  vfrt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .hold_i     (init_busy),
    .full_i     (q_full),
    .push_o     (push),
    .job_o      (front_job)
  );

  // decouples classification from slot bookkeeping
  vfrt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .pop_i   (pop),
    .job_o   (queue_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back end: slot table, seen marks, completion and result register
  vfrt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (queue_job),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .init_busy_o (init_busy),
    .out_o       (out_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule
`default_nettype wire

/* hw/rtl/vfrt_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module vfrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* hw/rtl/vfrt_front.sv */
// front end: takes descriptors and runs the stateless length and count checks
`timescale 1ns / 1ps
`default_nettype none
module vfrt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vfrt_pkg::in_item_t in_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               hold_i,
  input  logic               full_i,
  output logic               push_o,
  output vfrt_pkg::job_t     job_o
);
  import vfrt_pkg::*;

  localparam int PROD_W = 16 + $clog2(CHUNK_BYTES + 1);
  localparam int CMP_W  = ((PROD_W > 32) ? PROD_W : 32) + 2;

  front_state_e state_q, state_d;
  in_item_t     in_q;
  logic [PROD_W-1:0] cntk_q, cntk_d;
  logic [PROD_W-1:0] off_q, off_d;

  logic [CMP_W-1:0] size_x, cntk_x, off_x, rem_x, expect_x, plen_x;
  logic size_bad, cnt_bad, len_bad;

  assign in_stall_o = (state_q != F_IDLE) || hold_i;

  always_comb begin
    size_x   = CMP_W'(in_q.frame_bytes);
    cntk_x   = CMP_W'(cntk_q);
    off_x    = CMP_W'(off_q);
    rem_x    = size_x - off_x;
    expect_x = (rem_x < CMP_W'(CHUNK_BYTES)) ? rem_x : CMP_W'(CHUNK_BYTES);
    plen_x   = CMP_W'(in_q.fragment_length) - CMP_W'(HDR_BYTES);
    size_bad = (size_x < CMP_W'(HDR_BYTES)) || (size_x > CMP_W'(MAX_FRAME_BYTES));
    // count must equal ceil(size / chunk): (cnt-1)*chunk < size <= cnt*chunk
    cnt_bad  = (in_q.chunk_total == 16'd0) || (size_x > cntk_x) ||
               (size_x + CMP_W'(CHUNK_BYTES) <= cntk_x) ||
               (CMP_W'(in_q.chunk_total) > CMP_W'(MAX_CHUNKS)) ||
               (in_q.chunk_index >= in_q.chunk_total);
    len_bad  = plen_x != expect_x;

    job_o.frame_number = in_q.frame_number;
    job_o.is_keyframe  = in_q.is_keyframe;
    job_o.short_len    = in_q.fragment_length < 11'(HDR_BYTES);
    job_o.malformed    = size_bad || cnt_bad || len_bad;
    job_o.chunk_index  = CNT_W'(in_q.chunk_index);
    job_o.chunk_total  = CNT_W'(in_q.chunk_total);
    job_o.frame_bytes  = SIZE_W'(in_q.frame_bytes);
    job_o.offset       = SIZE_W'(off_q);
    job_o.first_word   = in_q.first_word;
    job_o.second_word  = in_q.second_word;
    job_o.now_ms       = in_q.now_ms;
  end

  always_comb begin
    state_d = state_q;
    cntk_d  = cntk_q;
    off_d   = off_q;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          state_d = F_MUL;
        end
      end
      F_MUL: begin
        cntk_d  = PROD_W'(in_q.chunk_total * CHUNK_BYTES);
        off_d   = PROD_W'(in_q.chunk_index * CHUNK_BYTES);
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_i;
    end
    cntk_q <= cntk_d;
    off_q  <= off_d;
  end

endmodule
`default_nettype wire

/* hw/rtl/vfrt_queue.sv */
// short queue of classified descriptors between front and back
`timescale 1ns / 1ps
`default_nettype none
module vfrt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vfrt_pkg::job_t job_i,
  input  logic           pop_i,
  output vfrt_pkg::job_t job_o,
  output logic           empty_o,
  output logic           full_o
);
  import vfrt_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

  job_t              entry_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  assign empty_o = fill_q == '0;
  assign full_o  = fill_q == FILL_W'(FIFO_DEPTH);
  assign job_o   = entry_q[rd_q];

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/vfrt_back.sv */
// back end: slot table, aging, eviction, seen-chunk memory and completion
`timescale 1ns / 1ps
`default_nettype none
module vfrt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vfrt_pkg::cfg_t      cfg_i,
  input  vfrt_pkg::job_t      job_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                init_busy_o,
  output vfrt_pkg::out_item_t out_o,
  output logic                out_valid_o,
  input  logic                out_stall_i
);
  import vfrt_pkg::*;

  back_state_e state_q, state_d;
  job_t        cur_q, cur_d;

  logic              valid_q [SLOTS];
  logic              valid_d [SLOTS];
  logic [63:0]       fid_q   [SLOTS];
  logic [63:0]       fid_d   [SLOTS];
  logic [SIZE_W-1:0] size_q  [SLOTS];
  logic [SIZE_W-1:0] size_d  [SLOTS];
  logic [CNT_W-1:0]  cnt_q   [SLOTS];
  logic [CNT_W-1:0]  cnt_d   [SLOTS];
  logic [CNT_W-1:0]  rcv_q   [SLOTS];
  logic [CNT_W-1:0]  rcv_d   [SLOTS];
  logic [31:0]       start_q [SLOTS];
  logic [31:0]       start_d [SLOTS];
  logic              kf_q    [SLOTS];
  logic              kf_d    [SLOTS];
  logic [31:0]       w_q     [SLOTS];
  logic [31:0]       w_d     [SLOTS];
  logic [31:0]       h_q     [SLOTS];
  logic [31:0]       h_d     [SLOTS];
  logic [EPOCH_W-1:0] epoch_q [SLOTS];
  logic [EPOCH_W-1:0] epoch_d [SLOTS];

  logic [63:0]        last_q, last_d;
  logic [SLOT_W-1:0]  pick_q, pick_d;
  logic [SLOT_W-1:0]  scan_q, scan_d;
  logic [63:0]        min_fid_q, min_fid_d;
  logic [SEEN_AW-1:0] sweep_addr_q, sweep_addr_d;
  logic [SEEN_AW-1:0] sweep_end_q, sweep_end_d;
  out_item_t          res_q, res_d;
  out_item_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               hit_found, free_found;
  logic [SLOT_W-1:0]  hit_idx, free_idx;
  logic [SEEN_AW-1:0] slot_base, seen_addr;
  logic               mem_we, mem_re;
  logic [SEEN_AW-1:0] mem_waddr;
  logic [EPOCH_W-1:0] mem_wdata, mem_rdata;
  logic               dim_bad;

  vfrt_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (SEEN_DEPTH)
  ) u_seen (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (seen_addr),
    .rdata_o (mem_rdata)
  );

  assign slot_base   = SEEN_AW'(pick_q * MAX_CHUNKS);
  assign seen_addr   = slot_base + SEEN_AW'(cur_q.chunk_index);
  assign init_busy_o = state_q == B_INIT;
  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  // lowest matching and lowest free slot
  always_comb begin
    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (!hit_found && valid_q[s] && fid_q[s] == cur_q.frame_number) begin
        hit_found = 1'b1;
        hit_idx   = SLOT_W'(s);
      end
      if (!free_found && !valid_q[s]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(s);
      end
    end
  end

  assign dim_bad = (w_q[pick_q] < 32'(cfg_i.min_dimension)) ||
                   (h_q[pick_q] < 32'(cfg_i.min_dimension)) ||
                   (w_q[pick_q] > 32'(cfg_i.max_width)) ||
                   (h_q[pick_q] > 32'(cfg_i.max_height));

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    valid_d      = valid_q;
    fid_d        = fid_q;
    size_d       = size_q;
    cnt_d        = cnt_q;
    rcv_d        = rcv_q;
    start_d      = start_q;
    kf_d         = kf_q;
    w_d          = w_q;
    h_d          = h_q;
    epoch_d      = epoch_q;
    last_d       = last_q;
    pick_d       = pick_q;
    scan_d       = scan_q;
    min_fid_d    = min_fid_q;
    sweep_addr_d = sweep_addr_q;
    sweep_end_d  = sweep_end_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    pop_o        = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = sweep_addr_q;
    mem_wdata    = '0;
    mem_re       = 1'b0;

    case (state_q)
      B_INIT, B_SWEEP: begin
        mem_we = 1'b1;
        if (sweep_addr_q == sweep_end_q) begin
          state_d = (state_q == B_INIT) ? B_IDLE : B_READ;
        end else begin
          sweep_addr_d = sweep_addr_q + SEEN_AW'(1);
        end
      end
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cur_d   = job_i;
          state_d = B_CHECK;
        end
      end
      B_CHECK: begin
        res_d = '0;
        if (cur_q.short_len || cur_q.frame_number <= last_q) begin
          res_d.status = ST_STALE;
          state_d      = B_OUT;
        end else if (cur_q.malformed) begin
          res_d.status = ST_MALFORMED;
          state_d      = B_OUT;
        end else begin
          for (int s = 0; s < SLOTS; s++) begin
            if (valid_q[s] && (cur_q.now_ms - start_q[s]) > 32'(cfg_i.timeout_ms)) begin
              valid_d[s] = 1'b0;
            end
          end
          state_d = B_LOOKUP;
        end
      end
      B_LOOKUP: begin
        if (hit_found) begin
          pick_d  = hit_idx;
          state_d = B_READ;
        end else if (free_found) begin
          pick_d  = free_idx;
          state_d = B_ALLOC;
        end else begin
          pick_d    = '0;
          min_fid_d = fid_q[0];
          scan_d    = SLOT_W'(1);
          state_d   = (SLOTS > 1) ? B_EVICT : B_ALLOC;
        end
      end
      B_EVICT: begin
        // one compare per cycle, strict less keeps the lowest index on ties
        if (fid_q[scan_q] < min_fid_q) begin
          pick_d    = scan_q;
          min_fid_d = fid_q[scan_q];
        end
        if (scan_q == SLOT_W'(SLOTS - 1)) begin
          state_d = B_ALLOC;
        end else begin
          scan_d = scan_q + SLOT_W'(1);
        end
      end
      B_ALLOC: begin
        valid_d[pick_q] = 1'b1;
        fid_d[pick_q]   = cur_q.frame_number;
        size_d[pick_q]  = cur_q.frame_bytes;
        cnt_d[pick_q]   = cur_q.chunk_total;
        rcv_d[pick_q]   = '0;
        start_d[pick_q] = cur_q.now_ms;
        kf_d[pick_q]    = cur_q.is_keyframe;
        w_d[pick_q]     = '0;
        h_d[pick_q]     = '0;
        // a new epoch retires all seen marks of the slot at once; on wrap the rows are swept
        if (epoch_q[pick_q] == EPOCH_LAST) begin
          epoch_d[pick_q] = EPOCH_FIRST;
          sweep_addr_d    = slot_base;
          sweep_end_d     = slot_base + SEEN_AW'(MAX_CHUNKS - 1);
          state_d         = B_SWEEP;
        end else begin
          epoch_d[pick_q] = epoch_q[pick_q] + EPOCH_W'(1);
          state_d         = B_READ;
        end
      end
      B_READ: begin
        mem_re  = 1'b1;
        state_d = B_TEST;
      end
      B_TEST: begin
        res_d = '0;
        if (size_q[pick_q] != cur_q.frame_bytes || cnt_q[pick_q] != cur_q.chunk_total ||
            mem_rdata == epoch_q[pick_q]) begin
          res_d.status = ST_DUPLICATE;
          state_d      = B_OUT;
        end else begin
          mem_we        = 1'b1;
          mem_waddr     = seen_addr;
          mem_wdata     = epoch_q[pick_q];
          rcv_d[pick_q] = rcv_q[pick_q] + CNT_W'(1);
          if (cur_q.chunk_index == '0) begin
            w_d[pick_q] = cur_q.first_word;
            h_d[pick_q] = cur_q.second_word;
          end
          res_d.slot         = 2'(pick_q);
          res_d.write_offset = 22'(cur_q.offset);
          if (rcv_q[pick_q] + CNT_W'(1) != cur_q.chunk_total) begin
            res_d.status = ST_STORED;
            state_d      = B_OUT;
          end else begin
            state_d = B_DONE;
          end
        end
      end
      B_DONE: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (valid_q[s] && fid_q[s] <= cur_q.frame_number) begin
            valid_d[s] = 1'b0;
          end
        end
        last_d               = cur_q.frame_number;
        res_d.status         = dim_bad ? ST_BAD_DIM : ST_COMPLETE;
        res_d.frame_keyframe = kf_q[pick_q];
        res_d.frame_width    = w_q[pick_q];
        res_d.frame_height   = h_q[pick_q];
        state_d              = B_OUT;
      end
      B_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_INIT;
      last_q       <= '0;
      out_valid_q  <= 1'b0;
      sweep_addr_q <= '0;
      sweep_end_q  <= SEEN_AW'(SEEN_DEPTH - 1);
      pick_q       <= '0;
      scan_q       <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        valid_q[s] <= 1'b0;
        epoch_q[s] <= EPOCH_FIRST;
      end
    end else begin
      state_q      <= state_d;
      last_q       <= last_d;
      out_valid_q  <= out_valid_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_end_q  <= sweep_end_d;
      pick_q       <= pick_d;
      scan_q       <= scan_d;
      valid_q      <= valid_d;
      epoch_q      <= epoch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    fid_q     <= fid_d;
    size_q    <= size_d;
    cnt_q     <= cnt_d;
    rcv_q     <= rcv_d;
    start_q   <= start_d;
    kf_q      <= kf_d;
    w_q       <= w_d;
    h_q       <= h_d;
    min_fid_q <= min_fid_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  a_mem_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == B_INIT || state_q == B_SWEEP || state_q == B_TEST))
    else $error("seen memory written outside sweep or test");

  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == B_IDLE && !empty_i))
    else $error("queue popped outside idle or while empty");

  a_epoch_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_READ) |-> (epoch_q[pick_q] != '0))
    else $error("slot epoch collides with cleared mark");

  a_last_recorded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DONE) |=> (last_q == $past(cur_q.frame_number)))
    else $error("completed frame id not recorded");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == B_OUT))
    else $error("result raised outside output state");

endmodule
`default_nettype wire
